>>> rtl/led_matrix_gray_scanner_defines.svh
// Assertion macros shared by the scanner RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef LED_MATRIX_GRAY_SCANNER_DEFINES_SVH
`define LED_MATRIX_GRAY_SCANNER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LMGS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LMGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lmgs_pkg.sv
// Shared constants, op codes and queue entry type for the LED matrix scanner.
// No dependencies.
package lmgs_pkg;

	localparam int MATRIX_DIM = 8;
	localparam int ROW_W      = $clog2(MATRIX_DIM);
	localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
	localparam int MEM_ROWS   = 2 ** (ROW_W + 1);
	localparam int ROW_BITS   = MATRIX_DIM * 8;

	localparam int CMD_W      = 2;
	localparam int IDX_W      = 6;
	localparam int LVL_W      = 8;
	localparam int ROWIDX_W   = 4;
	localparam int COL_W      = 8;
	localparam int CMP_W      = 9;

	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [7:0] DIV_RESET = 8'h1D;
	localparam logic [7:0] LVL_RESET = 8'h04;

	// input commands
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	// queued operations
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_SWAP    = 2'd1;
	localparam logic [1:0] OP_REFRESH = 2'd2;

	// register word indexes
	localparam logic REG_DIVIDER = 1'b0;
	localparam logic REG_LEVELS  = 1'b1;

	typedef struct packed {
		logic [1:0]       op;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [LVL_W-1:0] level;  // pixel level, or pass for a refresh
	} op_t;

	// row of a pixel index: count of row boundaries at or below it
	function automatic logic [ROW_W-1:0] pix_row(input logic [IDX_W-1:0] idx);
		logic [ROW_W-1:0] r;
		r = '0;
		for (int k = 1; k < MATRIX_DIM; k++) begin
			if (CMP_W'(idx) >= CMP_W'(k * MATRIX_DIM))
				r = r + ROW_W'(1);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] pix_col(input logic [IDX_W-1:0] idx,
			input logic [ROW_W-1:0] row);
		logic [CMP_W-1:0] base;
		base = CMP_W'(row) * CMP_W'(MATRIX_DIM);
		return ROW_W'(CMP_W'(idx) - base);
	endfunction

endpackage

>>> rtl/lmgs_front.sv
// Front end: takes input transactions, runs the tick prescaler and PWM pass,
// and queues write, swap and refresh ops. Depends on lmgs_pkg.
module lmgs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lmgs_pkg::CMD_W-1:0]    command,
	input  logic [lmgs_pkg::IDX_W-1:0]    pixel_index,
	input  logic [lmgs_pkg::LVL_W-1:0]    pixel_level,
	input  logic [7:0]                    tick_divider,
	input  logic [7:0]                    level_count,
	input  logic                          q_full,
	output logic                          q_push,
	output lmgs_pkg::op_t                 q_din
);

	logic [7:0]                   tick_q;
	logic [7:0]                   pass_q;
	logic [7:0]                   tick_nxt;
	logic [7:0]                   pass_nxt;
	logic                         take;
	logic                         fire;
	logic                         idx_ok;
	logic [lmgs_pkg::ROW_W-1:0]   row;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign tick_nxt = tick_q + 8'd1;
	assign fire     = take && (command == lmgs_pkg::CMD_TICK) && (tick_nxt == tick_divider);
	assign pass_nxt = (pass_q >= level_count) ? 8'd1 : pass_q + 8'd1;
	assign idx_ok   = lmgs_pkg::CMP_W'(pixel_index) < lmgs_pkg::CMP_W'(lmgs_pkg::CELLS);
	assign row      = lmgs_pkg::pix_row(pixel_index);

	always_comb begin
		q_push      = 1'b0;
		q_din.op    = lmgs_pkg::OP_WRITE;
		q_din.row   = row;
		q_din.col   = lmgs_pkg::pix_col(pixel_index, row);
		q_din.level = pixel_level;
		case (command)
			lmgs_pkg::CMD_WRITE: begin
				q_push = take && idx_ok;
			end
			lmgs_pkg::CMD_SWAP: begin
				q_push   = take;
				q_din.op = lmgs_pkg::OP_SWAP;
			end
			lmgs_pkg::CMD_TICK: begin
				q_push      = fire;
				q_din.op    = lmgs_pkg::OP_REFRESH;
				q_din.level = pass_nxt;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			pass_q <= '0;
		end else if (take && command == lmgs_pkg::CMD_TICK) begin
			tick_q <= fire ? 8'd0 : tick_nxt;
			if (fire)
				pass_q <= pass_nxt;
		end
	end

`include "led_matrix_gray_scanner_defines.svh"

	`LMGS_ASSERT_NEXT(a_tick_clears, fire, tick_q == 8'd0, "prescaler not cleared after refresh")
	`LMGS_ASSERT_SAME(a_pass_nonzero, q_push && q_din.op == lmgs_pkg::OP_REFRESH, q_din.level != 8'd0, "refresh queued with pass zero")

endmodule

>>> rtl/lmgs_queue.sv
// Short op queue between the front end and the row engine.
// Depends on lmgs_pkg.
module lmgs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lmgs_pkg::op_t  din,
	output logic           full,
	input  logic           pop,
	output lmgs_pkg::op_t  dout,
	output logic           empty
);

	lmgs_pkg::op_t                 ent_q [lmgs_pkg::QDEPTH];
	logic [lmgs_pkg::QPTR_W-1:0]   wr_q;
	logic [lmgs_pkg::QPTR_W-1:0]   rd_q;
	logic [lmgs_pkg::QCNT_W-1:0]   count_q;

	assign full  = count_q == lmgs_pkg::QCNT_W'(lmgs_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign dout  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + lmgs_pkg::QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + lmgs_pkg::QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + lmgs_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - lmgs_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`include "led_matrix_gray_scanner_defines.svh"

	`LMGS_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`LMGS_ASSERT_SAME(a_no_push_full, push, !full, "push into full queue")

endmodule

>>> rtl/lmgs_back.sv
// Row engine: executes queued ops on the double-buffered pixel store and
// emits row transactions through an output register. Depends on lmgs_pkg.
module lmgs_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  lmgs_pkg::op_t                    q_dout,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lmgs_pkg::ROWIDX_W-1:0]    row_index,
	output logic [lmgs_pkg::COL_W-1:0]       column_bits,
	output logic                             row_start,
	output logic                             last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROWS  = 2'd1;
	localparam logic [1:0] ST_BLANK = 2'd2;
	localparam int         AW       = lmgs_pkg::ROW_W + 1;
	localparam int         DIM      = lmgs_pkg::MATRIX_DIM;

	logic [lmgs_pkg::ROW_BITS-1:0]  mem_q [lmgs_pkg::MEM_ROWS];
	logic [DIM-1:0]                 vld_q [lmgs_pkg::MEM_ROWS];
	logic [lmgs_pkg::ROW_BITS-1:0]  rd_q;
	logic [DIM-1:0]                 rd_vld_q;

	logic [1:0]                     state_q;
	logic                           sel_q;
	logic [lmgs_pkg::ROW_W-1:0]     row_q;
	logic [lmgs_pkg::LVL_W-1:0]     pass_q;

	logic                           out_valid_q;
	logic [lmgs_pkg::ROWIDX_W-1:0]  out_row_q;
	logic [lmgs_pkg::COL_W-1:0]     out_col_q;
	logic                           out_start_q;
	logic                           out_last_q;

	logic                           load_ok;
	logic                           emit_row;
	logic                           emit_blank;
	logic                           do_write;
	logic [AW-1:0]                  rd_addr;
	logic [AW-1:0]                  wr_addr;
	logic [DIM-1:0]                 cols;

	assign load_ok    = !out_valid_q || out_ready;
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign do_write   = q_pop && q_dout.op == lmgs_pkg::OP_WRITE;
	assign emit_row   = (state_q == ST_ROWS) && load_ok;
	assign emit_blank = (state_q == ST_BLANK) && load_ok;
	assign wr_addr    = {!sel_q, q_dout.row};

	// next row to show; read data lands with the row counter
	always_comb begin
		rd_addr = {sel_q, row_q};
		if (state_q == ST_IDLE)
			rd_addr = {sel_q, lmgs_pkg::ROW_W'(DIM - 1)};
		else if (emit_row)
			rd_addr = {sel_q, row_q - lmgs_pkg::ROW_W'(1)};
	end

	// active low: a lit pixel clears its bit, column 0 in the top bit
	always_comb begin
		cols = '1;
		for (int c = 0; c < DIM; c++) begin
			if (rd_vld_q[c] && rd_q[c*8 +: 8] >= pass_q)
				cols[DIM-1-c] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write)
			mem_q[wr_addr][q_dout.col*8 +: 8] <= q_dout.level;
		rd_q     <= mem_q[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lmgs_pkg::MEM_ROWS; i++)
				vld_q[i] <= '0;
		end else if (do_write) begin
			vld_q[wr_addr][q_dout.col] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			row_q   <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_dout.op)
							lmgs_pkg::OP_SWAP: begin
								sel_q <= !sel_q;
							end
							lmgs_pkg::OP_REFRESH: begin
								pass_q  <= q_dout.level;
								row_q   <= lmgs_pkg::ROW_W'(DIM - 1);
								state_q <= ST_ROWS;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ROWS: begin
					if (emit_row) begin
						row_q <= row_q - lmgs_pkg::ROW_W'(1);
						if (row_q == '0)
							state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					if (emit_blank)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_ok)
			out_valid_q <= emit_row || emit_blank;
	end

	always_ff @(posedge clk) begin
		if (emit_row) begin
			out_row_q   <= lmgs_pkg::ROWIDX_W'(row_q);
			out_col_q   <= lmgs_pkg::COL_W'(cols);
			out_start_q <= row_q == lmgs_pkg::ROW_W'(DIM - 1);
			out_last_q  <= 1'b0;
		end else if (emit_blank) begin
			out_row_q   <= lmgs_pkg::ROWIDX_W'(DIM);
			out_col_q   <= '1;
			out_start_q <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_index   = out_row_q;
	assign column_bits = out_col_q;
	assign row_start   = out_start_q;
	assign last        = out_last_q;

`include "led_matrix_gray_scanner_defines.svh"

	`LMGS_ASSERT_SAME(a_blank_row, out_valid_q && out_last_q, out_row_q == lmgs_pkg::ROWIDX_W'(DIM), "blank transaction with wrong row")
	`LMGS_ASSERT_NEXT(a_refresh_starts, q_pop && q_dout.op == lmgs_pkg::OP_REFRESH, state_q == ST_ROWS, "refresh op did not start a run")

endmodule

>>> rtl/led_matrix_gray_scanner.sv
// Top level of the double-buffered 8x8 grayscale LED matrix scanner.
// Holds the APB registers; uses lmgs_pkg, lmgs_front, lmgs_queue, lmgs_back.
//
//  channel  | direction | handshake                  | contents
//  ---------+-----------+----------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready       | command, pixel_index, level
//  m_axis   | out       | m_axis_tvalid/tready       | row_index, column_bits, start, last
//  apb      | in        | psel/penable/pwrite/pready | tick_divider, level_count
//
// The front end takes one input transaction a cycle while the 4-entry op queue has room.
// The row engine completes each write or swap op as it dequeues it; a refresh op is dequeued,
// then yields nine output transactions at one a cycle while the output register drains.
// The single row engine takes no new op until a refresh is done; its memory reads one row
// per cycle. Stalls on m_axis back up into the queue, then into s_axis.
// Reset clears control state at once; per-pixel valid bits make the store read as zero,
// so no clearing pass is needed and input is taken from the first cycle after reset.
module led_matrix_gray_scanner (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [5:0] pixel_index, [13:6] pixel_level, [15:14] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] command

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [3:0] row_index, [11:4] column_bits, [15:12] zero
	output logic [0:0]  m_axis_tuser,   // [0] row_start
	output logic        m_axis_tlast,   // last

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]                           div_q;
	logic [7:0]                           lvl_q;
	logic                                 cfg_wr;

	logic                                 q_full;
	logic                                 q_empty;
	logic                                 q_push;
	logic                                 q_pop;
	lmgs_pkg::op_t                        q_din;
	lmgs_pkg::op_t                        q_dout;

	logic [lmgs_pkg::ROWIDX_W-1:0]        row_index;
	logic [lmgs_pkg::COL_W-1:0]           column_bits;
	logic                                 row_start;

	// register file: word address, low address bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= lmgs_pkg::DIV_RESET;
			lvl_q <= lmgs_pkg::LVL_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				lmgs_pkg::REG_DIVIDER: div_q <= pwdata[7:0];
				lmgs_pkg::REG_LEVELS:  lvl_q <= pwdata[7:0];
				default:               div_q <= div_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lmgs_pkg::REG_DIVIDER: prdata = {24'd0, div_q};
			lmgs_pkg::REG_LEVELS:  prdata = {24'd0, lvl_q};
			default:               prdata = '0;
		endcase
	end

	lmgs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.command      (s_axis_tuser),
		.pixel_index  (s_axis_tdata[5:0]),
		.pixel_level  (s_axis_tdata[13:6]),
		.tick_divider (div_q),
		.level_count  (lvl_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_din        (q_din)
	);

	lmgs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	lmgs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_dout      (q_dout),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.row_index   (row_index),
		.column_bits (column_bits),
		.row_start   (row_start),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata    = {4'd0, column_bits, row_index};
	assign m_axis_tuser[0] = row_start;

endmodule
